@@ src/stmm_pkg.sv @@
`default_nettype none

package stmm_pkg;

  // default sizes
  localparam int MAX_DIM_DEF      = 8;
  localparam int MAX_TRIPLETS_DEF = 64;

  // fixed field widths
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 16;
  localparam int ACC_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int OP_W      = 2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

  // command codes
  localparam logic [OP_W-1:0] OP_STORE_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [VAL_W-1:0] v;
  } trip_t;

  localparam int TRIP_W = $bits(trip_t);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             entry;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

@@ src/stmm_ram.sv @@
`default_nettype none

module stmm_ram #(
  parameter int WIDTH  = stmm_pkg::TRIP_W,
  parameter int ADDR_W = $clog2(stmm_pkg::MAX_TRIPLETS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/stmm_mac.sv @@
`default_nettype none

module stmm_mac #(
  parameter int DIM_W = $clog2(stmm_pkg::MAX_DIM_DEF)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       issue,
  input  stmm_pkg::trip_t            a_q,
  input  stmm_pkg::trip_t            b_q,
  input  logic [stmm_pkg::ACC_W-1:0] acc_rdata,
  output logic [2*DIM_W-1:0]         acc_raddr,
  output logic                       acc_we,
  output logic [2*DIM_W-1:0]         acc_waddr,
  output logic [stmm_pkg::ACC_W-1:0] acc_wdata
);

  localparam int ACC_AW = 2 * DIM_W;

  logic                              lookup;
  logic                              match;
  logic                              prod_vld;
  logic signed [stmm_pkg::ACC_W-1:0] prod;
  logic [ACC_AW-1:0]                 prod_addr;
  logic                              fwd_vld;
  logic [ACC_AW-1:0]                 fwd_addr;
  logic [stmm_pkg::ACC_W-1:0]        fwd_data;
  logic [stmm_pkg::ACC_W-1:0]        acc_old;

  // list data for the pair issued last cycle is on a_q / b_q
  assign match     = lookup && (a_q.c == b_q.r);
  assign acc_raddr = {DIM_W'(a_q.r), DIM_W'(b_q.c)};

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup   <= 1'b0;
      prod_vld <= 1'b0;
      fwd_vld  <= 1'b0;
    end else begin
      lookup   <= issue;
      prod_vld <= match;
      fwd_vld  <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= $signed(a_q.v) * $signed(b_q.v);
    prod_addr <= acc_raddr;
    fwd_addr  <= prod_addr;
    fwd_data  <= acc_wdata;
  end

  // the read for this sum went out in the cycle the previous sum was written
  assign acc_old   = (fwd_vld && (fwd_addr == prod_addr)) ? fwd_data : acc_rdata;
  assign acc_we    = prod_vld;
  assign acc_waddr = prod_addr;
  assign acc_wdata = acc_old + prod;

endmodule

`default_nettype wire

@@ src/stmm_emit.sv @@
`default_nettype none

module stmm_emit #(
  parameter int MAX_DIM = stmm_pkg::MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [$clog2(MAX_DIM+1)-1:0]         nr,
  input  logic [$clog2(MAX_DIM+1)-1:0]         nc,
  input  logic [stmm_pkg::ACC_W-1:0]           acc_rdata,
  output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] acc_raddr,
  output logic                                 done,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output stmm_pkg::res_t                       res
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int IW    = stmm_pkg::IDX_W;

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_READ  = 2'd1;
  localparam logic [1:0] E_CHECK = 2'd2;
  localparam logic [1:0] E_FLUSH = 2'd3;

  logic [1:0]                 estate;
  logic [CNT_W-1:0]           row;
  logic [CNT_W-1:0]           col;
  logic                       pend_vld;
  logic [IW-1:0]              pend_row;
  logic [IW-1:0]              pend_col;
  logic [stmm_pkg::ACC_W-1:0] pend_val;
  logic                       out_free;
  logic                       hit;
  logic                       hold;
  logic                       col_end;
  logic                       row_end;
  logic                       load;
  stmm_pkg::res_t             load_res;

  assign acc_raddr = {row[DIM_W-1:0], col[DIM_W-1:0]};
  assign out_free  = !result_valid || !result_stall;
  assign hit       = (acc_rdata != '0);
  // a new nonzero entry can only displace the pending one into a free output
  assign hold      = hit && pend_vld && !out_free;
  assign col_end   = ((col + CNT_W'(1)) == nc);
  assign row_end   = ((row + CNT_W'(1)) == nr);
  assign done      = (estate == E_FLUSH) && out_free;

  always_comb begin
    load           = 1'b0;
    load_res.row   = pend_row;
    load_res.col   = pend_col;
    load_res.value = pend_val;
    load_res.entry = 1'b1;
    load_res.last  = 1'b0;
    case (estate)
      E_CHECK: begin
        load = hit && pend_vld && out_free;
      end
      E_FLUSH: begin
        load          = out_free;
        load_res.last = 1'b1;
        if (!pend_vld) begin
          load_res.row   = '0;
          load_res.col   = '0;
          load_res.value = '0;
          load_res.entry = 1'b0;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estate       <= E_IDLE;
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (estate)
        E_IDLE: begin
          if (start) begin
            pend_vld <= 1'b0;
            estate   <= ((nr == '0) || (nc == '0)) ? E_FLUSH : E_READ;
          end
        end
        E_READ: begin
          estate <= E_CHECK;
        end
        E_CHECK: begin
          if (!hold) begin
            if (hit) begin
              pend_vld <= 1'b1;
            end
            if (col_end && row_end) begin
              estate <= E_FLUSH;
            end else begin
              estate <= E_READ;
            end
          end
        end
        E_FLUSH: begin
          if (out_free) begin
            estate <= E_IDLE;
          end
        end
        default: begin
          estate <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
    if ((estate == E_IDLE) && start) begin
      row <= '0;
      col <= '0;
    end else if ((estate == E_CHECK) && !hold) begin
      if (hit) begin
        pend_row <= IW'(row);
        pend_col <= IW'(col);
        pend_val <= acc_rdata;
      end
      if (col_end) begin
        col <= '0;
        row <= row + CNT_W'(1);
      end else begin
        col <= col + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sparse_triplet_matrix_multiply.sv @@
// Sparse matrix multiply on triplet lists.
// Input channel (item_valid / item_stall): op 0 stores an A triplet, op 1 a
// B triplet, op 2 runs the multiply, op 3 is ignored. Store beats are taken
// one per cycle; out of range triplets or triplets past list capacity are
// dropped silently. item_stall is high for the whole of a run.
// A run clears the accumulator RAM, walks every A x B pair at one pair per
// cycle (single read port on each list RAM), drains so the last sum reaches
// the RAM, then scans rows_a x cols_b sums, each entry read, then tested.
// Nonzero sums leave on result_valid / result_stall in row-major order, the
// final beat flagged last; an all-zero product gives a single beat with
// is_entry low. Both lists are empty afterwards.
// Results sit in an output register: a stalled beat holds, and the scan waits
// behind it once it finds another nonzero sum. The next command is taken once
// the final beat is in the output register, even if it has not been taken yet.
// Config writes (cfg_valid, cfg_ready always high) set rows_a (index 0) and
// cols_b (index 1); only write them while idle.
// Reset (rst, synchronous): lists empty, both sizes 8, no result pending.
`default_nettype none

module sparse_triplet_matrix_multiply #(
  parameter int MAX_DIM      = stmm_pkg::MAX_DIM_DEF,
  parameter int MAX_TRIPLETS = stmm_pkg::MAX_TRIPLETS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [stmm_pkg::OP_W-1:0]            op,
  input  logic [stmm_pkg::IDX_W-1:0]           row_index,
  input  logic [stmm_pkg::IDX_W-1:0]           col_index,
  input  logic signed [stmm_pkg::VAL_W-1:0]    elem_value,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [stmm_pkg::IDX_W-1:0]           out_row,
  output logic [stmm_pkg::IDX_W-1:0]           out_col,
  output logic signed [stmm_pkg::ACC_W-1:0]    out_value,
  output logic                                 is_entry,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stmm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int ACC_AW = 2 * DIM_W;
  localparam int LA_W   = (MAX_TRIPLETS > 1) ? $clog2(MAX_TRIPLETS) : 1;
  localparam int FILL_W = $clog2(MAX_TRIPLETS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]                 state;
  logic [stmm_pkg::CFG_W-1:0] rows_a;
  logic [stmm_pkg::CFG_W-1:0] cols_b;
  logic [FILL_W-1:0]          a_fill;
  logic [FILL_W-1:0]          b_fill;
  logic [LA_W-1:0]            ai;
  logic [LA_W-1:0]            bj;
  logic [ACC_AW-1:0]          clr_addr;
  logic                       drain_cnt;

  logic [CNT_W-1:0]           nr;
  logic [CNT_W-1:0]           nc;
  logic                       item_acc;
  logic                       store_a;
  logic                       store_b;
  logic                       ai_last;
  logic                       bj_last;
  logic                       emit_start;
  logic                       emit_done;
  stmm_pkg::trip_t            new_trip;
  stmm_pkg::trip_t            a_q;
  stmm_pkg::trip_t            b_q;
  stmm_pkg::res_t             res;

  logic                       mac_we;
  logic [ACC_AW-1:0]          mac_waddr;
  logic [stmm_pkg::ACC_W-1:0] mac_wdata;
  logic [ACC_AW-1:0]          mac_raddr;
  logic [ACC_AW-1:0]          emit_raddr;
  logic                       acc_we;
  logic [ACC_AW-1:0]          acc_waddr;
  logic [stmm_pkg::ACC_W-1:0] acc_wdata;
  logic [ACC_AW-1:0]          acc_raddr;
  logic [stmm_pkg::ACC_W-1:0] acc_rdata;

  // sizes saturate at MAX_DIM
  assign nr = (32'(rows_a) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(rows_a);
  assign nc = (32'(cols_b) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cols_b);

  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign store_a    = item_acc && (op == stmm_pkg::OP_STORE_A)
                      && (32'(a_fill) < MAX_TRIPLETS)
                      && (32'(row_index) < 32'(nr)) && (32'(col_index) < MAX_DIM);
  assign store_b    = item_acc && (op == stmm_pkg::OP_STORE_B)
                      && (32'(b_fill) < MAX_TRIPLETS)
                      && (32'(row_index) < MAX_DIM) && (32'(col_index) < 32'(nc));

  assign new_trip.r = row_index;
  assign new_trip.c = col_index;
  assign new_trip.v = elem_value;

  assign ai_last    = ((FILL_W'(ai) + FILL_W'(1)) == a_fill);
  assign bj_last    = ((FILL_W'(bj) + FILL_W'(1)) == b_fill);
  assign emit_start = (state == ST_DRAIN) && !drain_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= stmm_pkg::SIZE_RESET;
      cols_b <= stmm_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == stmm_pkg::CFG_ROWS_A) begin
        rows_a <= cfg_data;
      end
      if (cfg_index == stmm_pkg::CFG_COLS_B) begin
        cols_b <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      a_fill    <= '0;
      b_fill    <= '0;
      ai        <= '0;
      bj        <= '0;
      clr_addr  <= '0;
      drain_cnt <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (store_a) begin
            a_fill <= a_fill + FILL_W'(1);
          end
          if (store_b) begin
            b_fill <= b_fill + FILL_W'(1);
          end
          if (item_acc && (op == stmm_pkg::OP_MULTIPLY)) begin
            clr_addr <= '0;
            state    <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + ACC_AW'(1);
          if (&clr_addr) begin
            ai        <= '0;
            bj        <= '0;
            drain_cnt <= 1'b1;
            state     <= ((a_fill != '0) && (b_fill != '0)) ? ST_MAC : ST_DRAIN;
          end
        end
        ST_MAC: begin
          if (bj_last) begin
            bj <= '0;
            if (ai_last) begin
              state <= ST_DRAIN;
            end else begin
              ai <= ai + LA_W'(1);
            end
          end else begin
            bj <= bj + LA_W'(1);
          end
        end
        ST_DRAIN: begin
          // the drain lets the last sum reach the RAM before the scan reads it
          if (!drain_cnt) begin
            state <= ST_EMIT;
          end else begin
            drain_cnt <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (emit_done) begin
            a_fill <= '0;
            b_fill <= '0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  stmm_ram #(
    .WIDTH  (stmm_pkg::TRIP_W),
    .ADDR_W (LA_W)
  ) u_a_list (
    .clk   (clk),
    .we    (store_a),
    .waddr (a_fill[LA_W-1:0]),
    .wdata (new_trip),
    .raddr (ai),
    .rdata (a_q)
  );

  stmm_ram #(
    .WIDTH  (stmm_pkg::TRIP_W),
    .ADDR_W (LA_W)
  ) u_b_list (
    .clk   (clk),
    .we    (store_b),
    .waddr (b_fill[LA_W-1:0]),
    .wdata (new_trip),
    .raddr (bj),
    .rdata (b_q)
  );

  stmm_mac #(
    .DIM_W (DIM_W)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (state == ST_MAC),
    .a_q       (a_q),
    .b_q       (b_q),
    .acc_rdata (acc_rdata),
    .acc_raddr (mac_raddr),
    .acc_we    (mac_we),
    .acc_waddr (mac_waddr),
    .acc_wdata (mac_wdata)
  );

  assign acc_we    = (state == ST_CLEAR) || mac_we;
  assign acc_waddr = (state == ST_CLEAR) ? clr_addr : mac_waddr;
  assign acc_wdata = (state == ST_CLEAR) ? '0 : mac_wdata;
  assign acc_raddr = (state == ST_EMIT) ? emit_raddr : mac_raddr;

  stmm_ram #(
    .WIDTH  (stmm_pkg::ACC_W),
    .ADDR_W (ACC_AW)
  ) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  stmm_emit #(
    .MAX_DIM (MAX_DIM)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .start        (emit_start),
    .nr           (nr),
    .nc           (nc),
    .acc_rdata    (acc_rdata),
    .acc_raddr    (emit_raddr),
    .done         (emit_done),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res          (res)
  );

  assign out_row   = res.row;
  assign out_col   = res.col;
  assign out_value = res.value;
  assign is_entry  = res.entry;
  assign last      = res.last;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(a_fill) <= MAX_TRIPLETS) && (32'(b_fill) <= MAX_TRIPLETS))
    else $error("list fill count past capacity");

  a_pair_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> ((FILL_W'(ai) < a_fill) && (FILL_W'(bj) < b_fill)))
    else $error("pair walk outside filled lists");

  a_lists_emptied: assert property (@(posedge clk) disable iff (rst)
    emit_done |=> ((a_fill == '0) && (b_fill == '0) && (state == ST_IDLE)))
    else $error("lists not emptied after run");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_entry) |-> (last && (out_value == '0)))
    else $error("non-entry result not final or not zero");
`endif

endmodule

`default_nettype wire
